>>> design/ialu_pkg.sv
// Shared opcodes, defaults and types for the integer ALU with flags and branch unit.
`timescale 1ns / 1ps

package ialu_pkg;

  // Default register count
  localparam int NumRegsDefault = 16;

  // Shift amounts use the low five bits
  localparam int ShiftBits = 5;

  // Flag bit positions
  localparam int FlagZ = 0;
  localparam int FlagS = 1;
  localparam int FlagC = 2;
  localparam int FlagO = 3;

  typedef enum logic [5:0] {
    OP_ADD  = 6'd0,  OP_SUB  = 6'd1,  OP_MUL  = 6'd2,  OP_DIV  = 6'd3,
    OP_MOD  = 6'd4,  OP_AND  = 6'd5,  OP_OR   = 6'd6,  OP_XOR  = 6'd7,
    OP_NOT  = 6'd8,  OP_SHL  = 6'd9,  OP_SHR  = 6'd10, OP_SAR  = 6'd11,
    OP_INC  = 6'd12, OP_CMP  = 6'd13, OP_CMPI = 6'd14, OP_MOV  = 6'd15,
    OP_MOVI = 6'd16, OP_ADDI = 6'd17, OP_SUBI = 6'd18, OP_ANDI = 6'd19,
    OP_ORI  = 6'd20, OP_XORI = 6'd21, OP_SHLI = 6'd22, OP_SHRI = 6'd23,
    OP_JMP  = 6'd24, OP_JZ   = 6'd25, OP_JNZ  = 6'd26, OP_JG   = 6'd27,
    OP_JGE  = 6'd28, OP_JL   = 6'd29, OP_JLE  = 6'd30, OP_JC   = 6'd31,
    OP_JNC  = 6'd32
  } opcode_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_stat_t;

endpackage

>>> design/ialu_regfile.sv
// Register file memory: one write port, two registered read ports, per-entry valid bits.
`timescale 1ns / 1ps

module ialu_regfile #(
  parameter int NUM_REGS = ialu_pkg::NumRegsDefault,
  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [31:0]   rd_data_a,
  output logic [31:0]   rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [31:0]         rd_a_r;
  logic [31:0]         rd_b_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= valid_r[rd_addr_a] ? mem[rd_addr_a] : 32'd0;
      rd_b_r <= valid_r[rd_addr_b] ? mem[rd_addr_b] : 32'd0;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> design/ialu_divider.sv
// Signed 32-bit divider: restoring, one quotient bit per cycle.
`timescale 1ns / 1ps

module ialu_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [31:0]         divisor,
  output ialu_pkg::div_stat_t stat
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        qneg_r, qneg_nxt;
  logic        rneg_r, rneg_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  // One restoring step per cycle on magnitudes
  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    trial    = {rem_r, quo_r[31]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      cnt_nxt  = 6'd32;
      done_nxt = 1'b0;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      qneg_nxt = dividend[31] ^ divisor[31];
      rneg_nxt = dividend[31];
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      if (cnt_r == 6'd1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // Truncating quotient, remainder takes the dividend's sign
  assign stat.done = done_r;
  assign stat.quot = qneg_r ? (32'd0 - quo_r) : quo_r;
  assign stat.rem  = rneg_r ? (32'd0 - rem_r) : rem_r;

endmodule

>>> design/integer_alu_flags_branch_unit.sv
// Top level: sequencer, execute logic, flags and result register of the integer ALU.
`timescale 1ns / 1ps

// Executes one integer instruction per item against a register file of NUM_REGS
// 32-bit words (reset to zero) and four condition flags. An item reads the
// register file in the accept cycle, then executes and writes back. DIV and MOD
// with a nonzero divisor also pass through the bit-serial divider. A result
// waits in the output register while the next item is accepted; the block stalls
// write-back only if that register is still full. Register indexes are reduced
// modulo NUM_REGS.
module integer_alu_flags_branch_unit #(
  parameter int NUM_REGS = ialu_pkg::NumRegsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_command,
  input  logic [3:0]  in_dest_reg,
  input  logic [3:0]  in_src1_reg,
  input  logic [3:0]  in_src2_reg,
  input  logic signed [31:0] in_immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_value,
  output logic        out_reg_written,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_carry_flag,
  output logic        out_overflow_flag,
  output logic        out_branch_taken,
  output logic signed [31:0] out_branch_target,
  output logic        out_divide_fault,
  output logic        out_illegal_command
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cmd_r;
  logic [AW-1:0] dest_r;
  logic [31:0] imm_r;
  logic [3:0]  flags_r, flags_nxt;
  logic        accept;
  logic        out_free;
  logic        commit;
  logic        div_start;
  logic        is_div;
  logic [AW-1:0] idx_d, idx_1, idx_2;
  logic [AW-1:0] addr_a, addr_b;
  logic [31:0] opa, opb;
  ialu_pkg::div_stat_t div_stat;

  // Execute results
  logic [31:0] res;
  logic        wr;
  logic        taken;
  logic        dfault;
  logic        illegal;
  logic [32:0] add_sum;
  logic [31:0] add_b, sub_b, sub_r;
  logic        add_c, add_o, sub_c, sub_o;
  logic [31:0] mul_r;

  logic        out_valid_r;
  logic [31:0] out_res_r, out_tgt_r;
  logic        out_wr_r, out_taken_r, out_fault_r, out_ill_r;
  logic [3:0]  out_flags_r;

  // 4-bit index to register number: a 16-entry lookup built at elaboration
  function automatic logic [AW-1:0] reduce_idx(logic [3:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = AW'(i % NUM_REGS);
    end
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Register index reduction
  always_comb begin
    idx_d = reduce_idx(in_dest_reg);
    idx_1 = reduce_idx(in_src1_reg);
    idx_2 = reduce_idx(in_src2_reg);
  end

  // Port A: dest for INC/CMP/CMPI, else src1. Port B: src1 for CMP, else src2.
  always_comb begin
    addr_a = idx_1;
    addr_b = idx_2;
    case (in_command)
      ialu_pkg::OP_INC, ialu_pkg::OP_CMPI: addr_a = idx_d;
      ialu_pkg::OP_CMP: begin
        addr_a = idx_d;
        addr_b = idx_1;
      end
      default: ;
    endcase
  end

  ialu_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (opa),
    .rd_data_b (opb),
    .wr_en     (commit && wr),
    .wr_addr   (dest_r),
    .wr_data   (res)
  );

  ialu_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .stat     (div_stat)
  );

  // Latch the accepted command
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      dest_r <= idx_d;
      imm_r  <= in_immediate;
    end
  end

  assign is_div = ((cmd_r == ialu_pkg::OP_DIV) || (cmd_r == ialu_pkg::OP_MOD))
                  && (opb != 32'd0);

  // Adder and subtractor with strict-sign overflow, and the multiplier
  always_comb begin
    add_b = (cmd_r == ialu_pkg::OP_ADD) ? opb :
            (cmd_r == ialu_pkg::OP_INC) ? 32'd1 : imm_r;
    sub_b = ((cmd_r == ialu_pkg::OP_SUB) || (cmd_r == ialu_pkg::OP_CMP)) ? opb : imm_r;
    add_sum = {1'b0, opa} + {1'b0, add_b};
    add_c = add_sum[32];
    add_o = (!opa[31] && opa != 0 && !add_b[31] && add_b != 0 && add_sum[31]) ||
            (opa[31] && add_b[31] && !add_sum[31] && add_sum[31:0] != 0);
    sub_r = opa - sub_b;
    sub_c = opa < sub_b;
    sub_o = (!opa[31] && opa != 0 && sub_b[31] && sub_r[31]) ||
            (opa[31] && !sub_b[31] && sub_b != 0 && !sub_r[31] && sub_r != 0);
    mul_r = opa * opb;
  end

  // Instruction decode and result selection
  always_comb begin
    res       = 32'd0;
    wr        = 1'b1;
    taken     = 1'b0;
    dfault    = 1'b0;
    illegal   = 1'b0;
    flags_nxt = flags_r;
    case (cmd_r)
      ialu_pkg::OP_ADD, ialu_pkg::OP_INC, ialu_pkg::OP_ADDI: res = add_sum[31:0];
      ialu_pkg::OP_SUB, ialu_pkg::OP_SUBI: res = sub_r;
      ialu_pkg::OP_CMP, ialu_pkg::OP_CMPI: wr = 1'b0;
      ialu_pkg::OP_MUL:  res = mul_r;
      ialu_pkg::OP_DIV:  res = div_stat.quot;
      ialu_pkg::OP_MOD:  res = div_stat.rem;
      ialu_pkg::OP_AND:  res = opa & opb;
      ialu_pkg::OP_OR:   res = opa | opb;
      ialu_pkg::OP_XOR:  res = opa ^ opb;
      ialu_pkg::OP_NOT:  res = ~opa;
      ialu_pkg::OP_SHL:  res = opa << opb[ialu_pkg::ShiftBits-1:0];
      ialu_pkg::OP_SHR:  res = opa >> opb[ialu_pkg::ShiftBits-1:0];
      ialu_pkg::OP_SAR:  res = 32'($signed(opa) >>> opb[ialu_pkg::ShiftBits-1:0]);
      ialu_pkg::OP_MOV:  res = opa;
      ialu_pkg::OP_MOVI: res = imm_r;
      ialu_pkg::OP_ANDI: res = opa & imm_r;
      ialu_pkg::OP_ORI:  res = opa | imm_r;
      ialu_pkg::OP_XORI: res = opa ^ imm_r;
      ialu_pkg::OP_SHLI: res = opa << imm_r[ialu_pkg::ShiftBits-1:0];
      ialu_pkg::OP_SHRI: res = opa >> imm_r[ialu_pkg::ShiftBits-1:0];
      ialu_pkg::OP_JMP:  begin wr = 1'b0; taken = 1'b1; end
      ialu_pkg::OP_JZ:   begin wr = 1'b0; taken = flags_r[ialu_pkg::FlagZ]; end
      ialu_pkg::OP_JNZ:  begin wr = 1'b0; taken = !flags_r[ialu_pkg::FlagZ]; end
      ialu_pkg::OP_JG: begin
        wr    = 1'b0;
        taken = !flags_r[ialu_pkg::FlagZ] &&
                (flags_r[ialu_pkg::FlagS] == flags_r[ialu_pkg::FlagO]);
      end
      ialu_pkg::OP_JGE: begin
        wr    = 1'b0;
        taken = (flags_r[ialu_pkg::FlagS] == flags_r[ialu_pkg::FlagO]);
      end
      ialu_pkg::OP_JL: begin
        wr    = 1'b0;
        taken = (flags_r[ialu_pkg::FlagS] != flags_r[ialu_pkg::FlagO]);
      end
      ialu_pkg::OP_JLE: begin
        wr    = 1'b0;
        taken = flags_r[ialu_pkg::FlagZ] ||
                (flags_r[ialu_pkg::FlagS] != flags_r[ialu_pkg::FlagO]);
      end
      ialu_pkg::OP_JC:   begin wr = 1'b0; taken = flags_r[ialu_pkg::FlagC]; end
      ialu_pkg::OP_JNC:  begin wr = 1'b0; taken = !flags_r[ialu_pkg::FlagC]; end
      default: begin
        wr      = 1'b0;
        illegal = 1'b1;
      end
    endcase

    // Zero divisor faults and changes nothing
    if (((cmd_r == ialu_pkg::OP_DIV) || (cmd_r == ialu_pkg::OP_MOD)) && opb == 32'd0) begin
      wr     = 1'b0;
      dfault = 1'b1;
      res    = 32'd0;
    end

    // Flag update
    if (cmd_r inside {ialu_pkg::OP_ADD, ialu_pkg::OP_INC, ialu_pkg::OP_ADDI}) begin
      flags_nxt = {add_o, add_c, add_sum[31], add_sum[31:0] == 32'd0};
    end else if (cmd_r inside {ialu_pkg::OP_SUB, ialu_pkg::OP_SUBI,
                               ialu_pkg::OP_CMP, ialu_pkg::OP_CMPI}) begin
      flags_nxt = {sub_o, sub_c, sub_r[31], sub_r == 32'd0};
    end else if (wr) begin
      flags_nxt = {2'b00, res[31], res == 32'd0};
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_div) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done && out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r   <= wr ? res : 32'd0;
      out_wr_r    <= wr;
      out_flags_r <= flags_nxt;
      out_taken_r <= taken;
      out_tgt_r   <= taken ? imm_r : 32'd0;
      out_fault_r <= dfault;
      out_ill_r   <= illegal;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_res_r;
  assign out_reg_written     = out_wr_r;
  assign out_zero_flag       = out_flags_r[ialu_pkg::FlagZ];
  assign out_sign_flag       = out_flags_r[ialu_pkg::FlagS];
  assign out_carry_flag      = out_flags_r[ialu_pkg::FlagC];
  assign out_overflow_flag   = out_flags_r[ialu_pkg::FlagO];
  assign out_branch_taken    = out_taken_r;
  assign out_branch_target   = out_tgt_r;
  assign out_divide_fault    = out_fault_r;
  assign out_illegal_command = out_ill_r;

endmodule
